### rtl/smfp_pkg.sv
// ----------------------------------------------------------------------------
// smfp_pkg: shared types and constants for the MIDI file stream parser
// Parse phases, result kinds, the result item record and small helpers.
// ----------------------------------------------------------------------------
package smfp_pkg;

    localparam logic [2:0]  MAX_QUANTITY_BYTES = 3'd4;
    localparam logic [31:0] HDR_LEN_WORD       = 32'h0600_0000;
    localparam logic [15:0] MAX_FORMAT         = 16'h0002;
    localparam int          QUEUE_DEPTH        = 4;
    localparam int          MAX_RESULTS        = 3;

    localparam logic [7:0] ST_META    = 8'hFF;
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_ESCAPE  = 8'hF7;

    // result kinds
    localparam logic [3:0] KIND_HEADER   = 4'd0;
    localparam logic [3:0] KIND_HEAD     = 4'd1;
    localparam logic [3:0] KIND_DATA     = 4'd2;
    localparam logic [3:0] KIND_TRK_END  = 4'd3;
    localparam logic [3:0] KIND_BAD_ID   = 4'd4;
    localparam logic [3:0] KIND_BAD_HDR  = 4'd5;
    localparam logic [3:0] KIND_BAD_STAT = 4'd6;
    localparam logic [3:0] KIND_OVERFLOW = 4'd7;
    localparam logic [3:0] KIND_TRAILING = 4'd8;

    typedef enum logic [3:0] {
        PH_HDR_ID    = 4'd0,
        PH_HDR_LEN   = 4'd1,
        PH_HDR_FMT   = 4'd2,
        PH_HDR_NTRK  = 4'd3,
        PH_HDR_DIV   = 4'd4,
        PH_TRK_ID    = 4'd5,
        PH_TRK_LEN   = 4'd6,
        PH_DELTA     = 4'd7,
        PH_STATUS    = 4'd8,
        PH_META_TYPE = 4'd9,
        PH_LEN       = 4'd10,
        PH_DATA      = 4'd11,
        PH_DONE      = 4'd12,
        PH_HALT      = 4'd13
    } t_phase;

    typedef struct packed {
        logic [3:0]  kind;
        logic [27:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [7:0]  meta_type;
        logic [27:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_event;
        logic [1:0]  file_format;
        logic [15:0] track_count;
        logic        smpte_timing;
        logic [6:0]  frames_per_second;
        logic [14:0] ticks_value;
    } t_result;

    // up to three items produced by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    row2;
        t_result    row1;
        t_result    row0;
    } t_result_set;

    function automatic t_result mk_kind(input logic [3:0] kind);
        t_result r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic t_result mk_head(input logic [27:0] delta, input logic [7:0] status,
                                        input logic [7:0] meta, input logic [27:0] plen);
        t_result r;
        r                = '0;
        r.kind           = KIND_HEAD;
        r.delta_ticks    = delta;
        r.status_byte    = status;
        r.meta_type      = meta;
        r.payload_length = plen;
        r.last_of_event  = (plen == 28'd0);
        return r;
    endfunction

    function automatic t_result mk_data(input logic [7:0] status, input logic [7:0] meta,
                                        input logic [7:0] b, input logic last);
        t_result r;
        r               = '0;
        r.kind          = KIND_DATA;
        r.status_byte   = status;
        r.meta_type     = meta;
        r.payload_byte  = b;
        r.last_of_event = last;
        return r;
    endfunction

    // chunk id bytes: "MThd" or "MTrk"
    function automatic logic [7:0] id_byte(input logic is_hdr, input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = 8'h4D;
            2'd1:    v = is_hdr ? 8'h54 : 8'h54;
            2'd2:    v = is_hdr ? 8'h68 : 8'h72;
            default: v = is_hdr ? 8'h64 : 8'h6B;
        endcase
        return v;
    endfunction

    // program and channel pressure carry one data byte, other channel events two
    function automatic logic [27:0] channel_len(input logic [7:0] s);
        return (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 28'd1 : 28'd2;
    endfunction

endpackage

### rtl/smfp_parser.sv
// ----------------------------------------------------------------------------
// smfp_parser: byte-wise parse state and result generation
// Updates the parse state for each accepted byte and forms up to three items.
// ----------------------------------------------------------------------------
module smfp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_file_byte,
    output smfp_pkg::t_result_set o_set
);

    smfp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_fbc, n_fbc;
    logic [31:0] r_chunk, n_chunk;
    logic [15:0] r_tracks, n_tracks;
    logic [27:0] r_qacc, n_qacc;
    logic [2:0]  r_qb, n_qb;
    logic [27:0] r_delta, n_delta;
    logic [7:0]  r_estatus, n_estatus;
    logic [7:0]  r_running, n_running;
    logic [7:0]  r_meta, n_meta;
    logic [27:0] r_prem, n_prem;
    logic [15:0] r_hword, n_hword;

    smfp_pkg::t_result rows [smfp_pkg::MAX_RESULTS];
    logic [1:0]  cnt;
    logic        do_finish;
    logic [7:0]  b;
    logic [27:0] acc_new;
    logic [2:0]  qb_new;
    logic        q_done;
    logic        q_ovf;
    logic [15:0] hw_new;
    logic [31:0] len_shift;
    logic [27:0] clen;

    // next state and results for the byte at the input
    always_comb begin
        n_phase   = r_phase;
        n_fbc     = r_fbc;
        n_chunk   = r_chunk;
        n_tracks  = r_tracks;
        n_qacc    = r_qacc;
        n_qb      = r_qb;
        n_delta   = r_delta;
        n_estatus = r_estatus;
        n_running = r_running;
        n_meta    = r_meta;
        n_prem    = r_prem;
        n_hword   = r_hword;
        rows[0]   = '0;
        rows[1]   = '0;
        rows[2]   = '0;
        cnt       = 2'd0;
        do_finish = 1'b0;

        b         = i_file_byte;
        acc_new   = {r_qacc[20:0], b[6:0]};
        qb_new    = r_qb + 3'd1;
        q_done    = !b[7];
        q_ovf     = b[7] && (qb_new >= smfp_pkg::MAX_QUANTITY_BYTES);
        hw_new    = {r_hword[7:0], b};
        len_shift = smfp_pkg::HDR_LEN_WORD >> {r_fbc[1:0], 3'b000};
        clen      = smfp_pkg::channel_len(b);

        priority if (r_phase == smfp_pkg::PH_HALT) begin
            n_phase = smfp_pkg::PH_HALT;
        end else if (r_phase == smfp_pkg::PH_DONE) begin
            rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_TRAILING);
            cnt     = 2'd1;
            n_phase = smfp_pkg::PH_HALT;
        end else if (r_phase >= smfp_pkg::PH_DELTA && r_chunk == 32'd0) begin
            // event runs past its chunk
            rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_HDR);
            cnt     = 2'd1;
            n_phase = smfp_pkg::PH_HALT;
        end else begin
            if (r_phase >= smfp_pkg::PH_DELTA) begin
                n_chunk = r_chunk - 32'd1;
            end
            unique case (r_phase)
                smfp_pkg::PH_HDR_ID, smfp_pkg::PH_TRK_ID: begin
                    if (b != smfp_pkg::id_byte(r_phase == smfp_pkg::PH_HDR_ID, r_fbc[1:0])) begin
                        rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_ID);
                        cnt     = 2'd1;
                        n_phase = smfp_pkg::PH_HALT;
                    end else if (r_fbc == 3'd3) begin
                        n_fbc   = 3'd0;
                        n_chunk = 32'd0;
                        n_phase = (r_phase == smfp_pkg::PH_HDR_ID) ? smfp_pkg::PH_HDR_LEN
                                                                   : smfp_pkg::PH_TRK_LEN;
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                smfp_pkg::PH_HDR_LEN: begin
                    if (b != len_shift[7:0]) begin
                        rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_HDR);
                        cnt     = 2'd1;
                        n_phase = smfp_pkg::PH_HALT;
                    end else if (r_fbc == 3'd3) begin
                        n_fbc   = 3'd0;
                        n_hword = 16'd0;
                        n_phase = smfp_pkg::PH_HDR_FMT;
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                smfp_pkg::PH_HDR_FMT, smfp_pkg::PH_HDR_NTRK, smfp_pkg::PH_HDR_DIV: begin
                    n_hword = hw_new;
                    if (r_fbc == 3'd0) begin
                        n_fbc = 3'd1;
                    end else begin
                        n_fbc = 3'd0;
                        unique case (r_phase)
                            smfp_pkg::PH_HDR_FMT: begin
                                if (hw_new > smfp_pkg::MAX_FORMAT) begin
                                    rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_HDR);
                                    cnt     = 2'd1;
                                    n_phase = smfp_pkg::PH_HALT;
                                end else begin
                                    n_chunk = {16'd0, hw_new};
                                    n_phase = smfp_pkg::PH_HDR_NTRK;
                                end
                            end
                            smfp_pkg::PH_HDR_NTRK: begin
                                n_tracks = hw_new;
                                n_phase  = smfp_pkg::PH_HDR_DIV;
                            end
                            default: begin
                                rows[0]              = smfp_pkg::mk_kind(smfp_pkg::KIND_HEADER);
                                rows[0].file_format  = r_chunk[1:0];
                                rows[0].track_count  = r_tracks;
                                rows[0].smpte_timing = hw_new[15];
                                rows[0].frames_per_second = hw_new[15] ? hw_new[14:8] : 7'd0;
                                rows[0].ticks_value  = hw_new[15] ? {7'd0, hw_new[7:0]}
                                                                  : hw_new[14:0];
                                cnt     = 2'd1;
                                n_chunk = 32'd0;
                                n_phase = (r_tracks == 16'd0) ? smfp_pkg::PH_DONE
                                                              : smfp_pkg::PH_TRK_ID;
                            end
                        endcase
                    end
                end
                smfp_pkg::PH_TRK_LEN: begin
                    n_chunk = {r_chunk[23:0], b};
                    if (r_fbc == 3'd3) begin
                        n_fbc = 3'd0;
                        if (n_chunk == 32'd0) begin
                            rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_HDR);
                            cnt     = 2'd1;
                            n_phase = smfp_pkg::PH_HALT;
                        end else begin
                            n_running = 8'd0;
                            n_qacc    = 28'd0;
                            n_qb      = 3'd0;
                            n_phase   = smfp_pkg::PH_DELTA;
                        end
                    end else begin
                        n_fbc = r_fbc + 3'd1;
                    end
                end
                smfp_pkg::PH_DELTA: begin
                    if (q_ovf) begin
                        rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_OVERFLOW);
                        cnt     = 2'd1;
                        n_phase = smfp_pkg::PH_HALT;
                    end else if (q_done) begin
                        n_delta = acc_new;
                        n_qacc  = 28'd0;
                        n_qb    = 3'd0;
                        n_phase = smfp_pkg::PH_STATUS;
                    end else begin
                        n_qacc = acc_new;
                        n_qb   = qb_new;
                    end
                end
                smfp_pkg::PH_STATUS: begin
                    priority if (b == smfp_pkg::ST_META) begin
                        n_estatus = b;
                        n_running = 8'd0;
                        n_phase   = smfp_pkg::PH_META_TYPE;
                    end else if (b == smfp_pkg::ST_SYSEX || b == smfp_pkg::ST_ESCAPE) begin
                        n_estatus = b;
                        n_meta    = 8'd0;
                        n_running = 8'd0;
                        n_qacc    = 28'd0;
                        n_qb      = 3'd0;
                        n_phase   = smfp_pkg::PH_LEN;
                    end else if (b[7:4] == 4'hF) begin
                        rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_STAT);
                        cnt     = 2'd1;
                        n_phase = smfp_pkg::PH_HALT;
                    end else if (b[7]) begin
                        // new channel status
                        n_meta    = 8'd0;
                        n_running = b;
                        n_estatus = b;
                        n_prem    = clen;
                        rows[0]   = smfp_pkg::mk_head(r_delta, b, 8'd0, clen);
                        cnt       = 2'd1;
                        n_phase   = smfp_pkg::PH_DATA;
                    end else if (r_running == 8'd0) begin
                        rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_BAD_STAT);
                        cnt     = 2'd1;
                        n_phase = smfp_pkg::PH_HALT;
                    end else begin
                        // running status: head plus first data byte
                        n_meta    = 8'd0;
                        n_estatus = r_running;
                        n_prem    = smfp_pkg::channel_len(r_running) - 28'd1;
                        rows[0]   = smfp_pkg::mk_head(r_delta, r_running, 8'd0,
                                                      smfp_pkg::channel_len(r_running));
                        rows[1]   = smfp_pkg::mk_data(r_running, 8'd0, b, n_prem == 28'd0);
                        cnt       = 2'd2;
                        if (n_prem == 28'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase = smfp_pkg::PH_DATA;
                        end
                    end
                end
                smfp_pkg::PH_META_TYPE: begin
                    n_meta  = b;
                    n_qacc  = 28'd0;
                    n_qb    = 3'd0;
                    n_phase = smfp_pkg::PH_LEN;
                end
                smfp_pkg::PH_LEN: begin
                    if (q_ovf) begin
                        rows[0] = smfp_pkg::mk_kind(smfp_pkg::KIND_OVERFLOW);
                        cnt     = 2'd1;
                        n_phase = smfp_pkg::PH_HALT;
                    end else if (!q_done) begin
                        n_qacc = acc_new;
                        n_qb   = qb_new;
                    end else begin
                        n_prem  = acc_new;
                        n_qacc  = 28'd0;
                        n_qb    = 3'd0;
                        rows[0] = smfp_pkg::mk_head(r_delta, r_estatus, r_meta, acc_new);
                        cnt     = 2'd1;
                        if (acc_new == 28'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase = smfp_pkg::PH_DATA;
                        end
                    end
                end
                smfp_pkg::PH_DATA: begin
                    n_prem  = r_prem - 28'd1;
                    rows[0] = smfp_pkg::mk_data(r_estatus, r_meta, b, n_prem == 28'd0);
                    cnt     = 2'd1;
                    if (n_prem == 28'd0) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = smfp_pkg::PH_HALT;
                end
            endcase
        end

        // end of event: next delta or end of track chunk
        if (do_finish) begin
            n_qacc = 28'd0;
            n_qb   = 3'd0;
            if (n_chunk != 32'd0) begin
                n_phase = smfp_pkg::PH_DELTA;
            end else begin
                rows[cnt] = smfp_pkg::mk_kind(smfp_pkg::KIND_TRK_END);
                cnt       = cnt + 2'd1;
                n_tracks  = r_tracks - 16'd1;
                n_fbc     = 3'd0;
                n_phase   = (n_tracks == 16'd0) ? smfp_pkg::PH_DONE : smfp_pkg::PH_TRK_ID;
            end
        end
    end

    // items handed to the result queue
    always_comb begin
        o_set.cnt  = i_take ? cnt : 2'd0;
        o_set.row0 = rows[0];
        o_set.row1 = rows[1];
        o_set.row2 = rows[2];
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= smfp_pkg::PH_HDR_ID;
            r_fbc     <= '0;
            r_chunk   <= '0;
            r_tracks  <= '0;
            r_qacc    <= '0;
            r_qb      <= '0;
            r_delta   <= '0;
            r_estatus <= '0;
            r_running <= '0;
            r_meta    <= '0;
            r_prem    <= '0;
            r_hword   <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_fbc     <= n_fbc;
            r_chunk   <= n_chunk;
            r_tracks  <= n_tracks;
            r_qacc    <= n_qacc;
            r_qb      <= n_qb;
            r_delta   <= n_delta;
            r_estatus <= n_estatus;
            r_running <= n_running;
            r_meta    <= n_meta;
            r_prem    <= n_prem;
            r_hword   <= n_hword;
        end
    end

endmodule

### rtl/smfp_result_queue.sv
// ----------------------------------------------------------------------------
// smfp_result_queue: four-entry result queue
// Takes up to three items per cycle from the parser, delivers one per cycle while i_pop is high.
// ----------------------------------------------------------------------------
module smfp_result_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smfp_pkg::t_result_set i_set,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_room,
    output smfp_pkg::t_result     o_head
);

    smfp_pkg::t_result r_mem [smfp_pkg::QUEUE_DEPTH];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;
    smfp_pkg::t_result wr_rows [smfp_pkg::MAX_RESULTS];

    assign o_valid = (r_count != 3'd0);
    // three free entries even when nothing is popped this cycle
    assign o_room  = (r_count <= 3'd1);
    assign o_head  = r_mem[r_rptr];
    assign pop     = o_valid && i_pop;
    assign n_count = r_count + {1'b0, i_set.cnt} - {2'b00, pop};

    assign wr_rows[0] = i_set.row0;
    assign wr_rows[1] = i_set.row1;
    assign wr_rows[2] = i_set.row2;

    // entry storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < smfp_pkg::MAX_RESULTS; k++) begin
            if (2'(k) < i_set.cnt) begin
                r_mem[r_wptr + 2'(k)] <= wr_rows[k];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + i_set.cnt;
            r_rptr  <= r_rptr + {1'b0, pop};
            r_count <= n_count;
        end
    end

endmodule

### rtl/midi_file_stream_parser_top.sv
// ----------------------------------------------------------------------------
// midi_file_stream_parser_top: Standard MIDI File byte stream parser
// Feed the file one byte per input item (i_valid / o_stall). Results leave
// on the output channel (o_valid / i_stall): header, event heads, data bytes,
// track ends and one error item, after which the block halts until reset.
// An accepted byte's results are written into the result queue and leave it
// one per cycle while i_stall is low, in order.
// Throughput: one byte per cycle while each byte yields at most one result and i_stall is low.
// A byte can yield up to three results (head, data byte, track end); the
// four-entry result queue then holds o_stall high until it drains to one
// entry.
// When the receiver raises i_stall the queue fills and o_stall follows;
// the presented result holds until taken.
// Reset (i_rst_n low, synchronous) empties the queue and returns the parser
// to expecting the header chunk id.
// ----------------------------------------------------------------------------
module midi_file_stream_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_file_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic [27:0] o_delta_ticks,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_meta_type,
    output logic [27:0] o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_event,
    output logic [1:0]  o_file_format,
    output logic [15:0] o_track_count,
    output logic        o_smpte_timing,
    output logic [6:0]  o_frames_per_second,
    output logic [14:0] o_ticks_value
);

    smfp_pkg::t_result_set set;
    smfp_pkg::t_result     head;
    logic                  room;
    logic                  take;

    assign o_stall = !room;
    assign take    = i_valid && room;

    smfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_file_byte (i_file_byte),
        .o_set       (set)
    );

    smfp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_set   (set),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_room  (room),
        .o_head  (head)
    );

    // result fields
    assign o_kind              = head.kind;
    assign o_delta_ticks       = head.delta_ticks;
    assign o_status_byte       = head.status_byte;
    assign o_meta_type         = head.meta_type;
    assign o_payload_length    = head.payload_length;
    assign o_payload_byte      = head.payload_byte;
    assign o_last_of_event     = head.last_of_event;
    assign o_file_format       = head.file_format;
    assign o_track_count       = head.track_count;
    assign o_smpte_timing      = head.smpte_timing;
    assign o_frames_per_second = head.frames_per_second;
    assign o_ticks_value       = head.ticks_value;

endmodule

### rtl/smfp_checker.sv
// ----------------------------------------------------------------------------
// smfp_checker: port-level checks for the MIDI file stream parser
// Watches the top-level ports and flags violations of expected behavior.
// ----------------------------------------------------------------------------
module smfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_kind,
    input logic [27:0] o_payload_length,
    input logic        o_last_of_event
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_payload_length))
        else $error("stalled result changed");

    // nothing follows an error item
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind >= smfp_pkg::KIND_BAD_ID |=> !o_valid)
        else $error("result after error item");

    // kind stays within the defined codes
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind <= smfp_pkg::KIND_TRAILING)
        else $error("undefined result kind");

    // an event head is final exactly when it has no payload
    a_head_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == smfp_pkg::KIND_HEAD |-> o_last_of_event == (o_payload_length == 28'd0))
        else $error("head last flag wrong");

    // queue is empty after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind midi_file_stream_parser_top smfp_checker u_smfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_payload_length (o_payload_length),
    .o_last_of_event  (o_last_of_event)
);

### dv/tb_midi_file_stream_parser_top.sv
// ----------------------------------------------------------------------------
// tb_midi_file_stream_parser_top: self-checking bench for the MIDI file parser
// Builds one Standard MIDI File as a byte stream: a directed header and first
// track, then random tracks of well-formed events. The stream ends in one
// randomly chosen error or trailing byte, then noise that must be ignored.
// A behavioral parser predicts every result item. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_midi_file_stream_parser_top;

    localparam int N_TRACKS  = 12;
    localparam int LIMIT_CYC = 200000;
    localparam int CALM_TAIL = 60;

    localparam logic [7:0] HDR_TAG [4] = '{8'h4D, 8'h54, 8'h68, 8'h64};
    localparam logic [7:0] TRK_TAG [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

    // ways the file is made to end
    typedef enum int {
        END_TRAILING, END_BAD_ID, END_BAD_STATUS, END_OVERFLOW,
        END_EMPTY_TRACK, END_NO_RUNNING, END_PAST_CHUNK
    } t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_file_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_kind;
    logic [27:0] o_delta_ticks;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_meta_type;
    logic [27:0] o_payload_length;
    logic [7:0]  o_payload_byte;
    logic        o_last_of_event;
    logic [1:0]  o_file_format;
    logic [15:0] o_track_count;
    logic        o_smpte_timing;
    logic [6:0]  o_frames_per_second;
    logic [14:0] o_ticks_value;

    midi_file_stream_parser_top dut (.*);

    always #6 i_clk = ~i_clk;

    // stream to send, and typed-in results for some directed rows
    logic [7:0]        file_q [$];
    bit                pinned_q [$];
    smfp_pkg::t_result pinned_res_q [$];
    logic [7:0]        trk_buf [$];
    smfp_pkg::t_result pending_results [$];

    int  mismatch_cnt = 0;
    int  n_accepted = 0;
    int  n_taken = 0;
    int  cycle_cnt = 0;
    int  pause_at = 0;
    bit  calm = 1'b0;

    // ---------------- parser prediction ----------------
    smfp_pkg::t_phase ph;
    logic [3:0]  fcnt;
    logic [31:0] chunk_left;
    logic [15:0] trk_left;
    logic [27:0] acc;
    logic [2:0]  nq;
    logic [27:0] ev_delta;
    logic [7:0]  ev_status;
    logic [7:0]  run_status;
    logic [7:0]  meta_t;
    logic [27:0] pay_left;
    logic [15:0] hword;

    function automatic void push_kind(logic [3:0] k);
        smfp_pkg::t_result r;
        r = '0;
        r.kind = k;
        pending_results.push_back(r);
    endfunction

    function automatic void halt_with(logic [3:0] k);
        push_kind(k);
        ph = smfp_pkg::PH_HALT;
    endfunction

    function automatic int vlq_step(logic [7:0] b);
        acc = {acc[20:0], b[6:0]};
        nq  = nq + 3'd1;
        if (!b[7]) return 1;
        if (nq >= smfp_pkg::MAX_QUANTITY_BYTES) return -1;
        return 0;
    endfunction

    function automatic void push_head(logic [27:0] plen);
        smfp_pkg::t_result r;
        r = '0;
        r.kind           = smfp_pkg::KIND_HEAD;
        r.delta_ticks    = ev_delta;
        r.status_byte    = ev_status;
        r.meta_type      = meta_t;
        r.payload_length = plen;
        r.last_of_event  = (plen == 28'd0);
        pending_results.push_back(r);
    endfunction

    function automatic void push_data(logic [7:0] b, logic last);
        smfp_pkg::t_result r;
        r = '0;
        r.kind          = smfp_pkg::KIND_DATA;
        r.status_byte   = ev_status;
        r.meta_type     = meta_t;
        r.payload_byte  = b;
        r.last_of_event = last;
        pending_results.push_back(r);
    endfunction

    function automatic void close_event();
        acc = '0;
        nq  = '0;
        if (chunk_left != 0) begin
            ph = smfp_pkg::PH_DELTA;
            return;
        end
        push_kind(smfp_pkg::KIND_TRK_END);
        trk_left = trk_left - 16'd1;
        fcnt = '0;
        ph = (trk_left == 0) ? smfp_pkg::PH_DONE : smfp_pkg::PH_TRK_ID;
    endfunction

    function automatic logic [27:0] chan_bytes(logic [7:0] s);
        return (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 28'd1 : 28'd2;
    endfunction

    function automatic void parse_reset();
        ph = smfp_pkg::PH_HDR_ID;
        fcnt = '0; chunk_left = '0; trk_left = '0; acc = '0; nq = '0;
        ev_delta = '0; ev_status = '0; run_status = '0; meta_t = '0;
        pay_left = '0; hword = '0;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int q;
        smfp_pkg::t_result r;
        logic [7:0] tag;
        if (ph == smfp_pkg::PH_HALT) return;
        if (ph == smfp_pkg::PH_DONE) begin
            halt_with(smfp_pkg::KIND_TRAILING);
            return;
        end
        if (ph >= smfp_pkg::PH_DELTA && ph <= smfp_pkg::PH_DATA) begin
            if (chunk_left == 0) begin
                halt_with(smfp_pkg::KIND_BAD_HDR);
                return;
            end
            chunk_left = chunk_left - 32'd1;
        end
        case (ph)
            smfp_pkg::PH_HDR_ID, smfp_pkg::PH_TRK_ID: begin
                tag = (ph == smfp_pkg::PH_HDR_ID) ? HDR_TAG[fcnt[1:0]] : TRK_TAG[fcnt[1:0]];
                if (b != tag) begin
                    halt_with(smfp_pkg::KIND_BAD_ID);
                    return;
                end
                fcnt = fcnt + 4'd1;
                if (fcnt >= 4) begin
                    fcnt = '0;
                    chunk_left = '0;
                    ph = (ph == smfp_pkg::PH_HDR_ID) ? smfp_pkg::PH_HDR_LEN
                                                     : smfp_pkg::PH_TRK_LEN;
                end
            end
            smfp_pkg::PH_HDR_LEN: begin
                if (b != smfp_pkg::HDR_LEN_WORD[8*fcnt[1:0] +: 8]) begin
                    halt_with(smfp_pkg::KIND_BAD_HDR);
                    return;
                end
                fcnt = fcnt + 4'd1;
                if (fcnt >= 4) begin
                    fcnt = '0;
                    hword = '0;
                    ph = smfp_pkg::PH_HDR_FMT;
                end
            end
            smfp_pkg::PH_HDR_FMT, smfp_pkg::PH_HDR_NTRK, smfp_pkg::PH_HDR_DIV: begin
                hword = {hword[7:0], b};
                fcnt = fcnt + 4'd1;
                if (fcnt < 2) return;
                fcnt = '0;
                if (ph == smfp_pkg::PH_HDR_FMT) begin
                    if (hword > smfp_pkg::MAX_FORMAT) begin
                        halt_with(smfp_pkg::KIND_BAD_HDR);
                        return;
                    end
                    chunk_left = {16'd0, hword};
                    ph = smfp_pkg::PH_HDR_NTRK;
                end else if (ph == smfp_pkg::PH_HDR_NTRK) begin
                    trk_left = hword;
                    ph = smfp_pkg::PH_HDR_DIV;
                end else begin
                    r = '0;
                    r.kind              = smfp_pkg::KIND_HEADER;
                    r.file_format       = chunk_left[1:0];
                    r.track_count       = trk_left;
                    r.smpte_timing      = hword[15];
                    r.frames_per_second = hword[15] ? hword[14:8] : 7'd0;
                    r.ticks_value       = hword[15] ? {7'd0, hword[7:0]} : hword[14:0];
                    pending_results.push_back(r);
                    chunk_left = '0;
                    ph = (trk_left == 0) ? smfp_pkg::PH_DONE : smfp_pkg::PH_TRK_ID;
                end
            end
            smfp_pkg::PH_TRK_LEN: begin
                chunk_left = {chunk_left[23:0], b};
                fcnt = fcnt + 4'd1;
                if (fcnt >= 4) begin
                    fcnt = '0;
                    if (chunk_left == 0) begin
                        halt_with(smfp_pkg::KIND_BAD_HDR);
                        return;
                    end
                    run_status = '0;
                    acc = '0; nq = '0;
                    ph = smfp_pkg::PH_DELTA;
                end
            end
            smfp_pkg::PH_DELTA: begin
                q = vlq_step(b);
                if (q < 0) begin
                    halt_with(smfp_pkg::KIND_OVERFLOW);
                    return;
                end
                if (q > 0) begin
                    ev_delta = acc;
                    acc = '0; nq = '0;
                    ph = smfp_pkg::PH_STATUS;
                end
            end
            smfp_pkg::PH_STATUS: begin
                if (b == smfp_pkg::ST_META) begin
                    ev_status = b;
                    run_status = '0;
                    ph = smfp_pkg::PH_META_TYPE;
                end else if (b == smfp_pkg::ST_SYSEX || b == smfp_pkg::ST_ESCAPE) begin
                    ev_status = b;
                    meta_t = '0;
                    run_status = '0;
                    acc = '0; nq = '0;
                    ph = smfp_pkg::PH_LEN;
                end else if (b >= 8'hF0) begin
                    halt_with(smfp_pkg::KIND_BAD_STAT);
                end else begin
                    meta_t = '0;
                    if (b[7]) begin
                        run_status = b;
                        ev_status = b;
                        pay_left = chan_bytes(b);
                        push_head(pay_left);
                        ph = smfp_pkg::PH_DATA;
                    end else if (run_status == 0) begin
                        halt_with(smfp_pkg::KIND_BAD_STAT);
                    end else begin
                        // running status: this byte is already the first data byte
                        ev_status = run_status;
                        pay_left = chan_bytes(ev_status);
                        push_head(pay_left);
                        pay_left = pay_left - 28'd1;
                        push_data(b, pay_left == 0);
                        if (pay_left == 0) close_event();
                        else ph = smfp_pkg::PH_DATA;
                    end
                end
            end
            smfp_pkg::PH_META_TYPE: begin
                meta_t = b;
                acc = '0; nq = '0;
                ph = smfp_pkg::PH_LEN;
            end
            smfp_pkg::PH_LEN: begin
                q = vlq_step(b);
                if (q < 0) begin
                    halt_with(smfp_pkg::KIND_OVERFLOW);
                    return;
                end
                if (q == 0) return;
                pay_left = acc;
                acc = '0; nq = '0;
                push_head(pay_left);
                if (pay_left == 0) close_event();
                else ph = smfp_pkg::PH_DATA;
            end
            smfp_pkg::PH_DATA: begin
                pay_left = pay_left - 28'd1;
                push_data(b, pay_left == 0);
                if (pay_left == 0) close_event();
            end
            default: ph = smfp_pkg::PH_HALT;
        endcase
    endfunction

    // ---------------- stream building ----------------
    function automatic void put_byte(logic [7:0] b);
        file_q.push_back(b);
        pinned_q.push_back(1'b0);
        pinned_res_q.push_back('0);
    endfunction

    function automatic void put_pinned(logic [7:0] b, smfp_pkg::t_result r);
        file_q.push_back(b);
        pinned_q.push_back(1'b1);
        pinned_res_q.push_back(r);
    endfunction

    function automatic void vlq_to_trk(logic [27:0] v);
        int n;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0) n++;
        for (int i = n - 1; i >= 0; i--)
            trk_buf.push_back({(i != 0), 7'((v >> (7 * i)) & 28'h7F)});
    endfunction

    function automatic logic [27:0] rand_delta();
        case ($urandom_range(0, 9))
            0:       return 28'($urandom_range(0, 28'h0FFFFFFF));
            1:       return 28'($urandom_range(128, 20000));
            default: return 28'($urandom_range(0, 127));
        endcase
    endfunction

    // one random well-formed event into trk_buf; trk_run holds running status
    function automatic void add_event(ref logic [7:0] trk_run);
        int sel;
        int len;
        logic [7:0] s;
        sel = $urandom_range(0, 9);
        vlq_to_trk(rand_delta());
        if (sel >= 5 && sel <= 6 && trk_run != 0) begin
            trk_buf.push_back(8'($urandom_range(0, 127)));
            if (chan_bytes(trk_run) == 2) trk_buf.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 7) begin
            s = 8'($urandom_range(8'h80, 8'hEF));
            trk_buf.push_back(s);
            repeat (chan_bytes(s)) trk_buf.push_back(8'($urandom_range(0, 255)));
            trk_run = s;
        end else begin
            if (sel == 7) begin
                trk_buf.push_back(smfp_pkg::ST_META);
                trk_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                trk_buf.push_back($urandom_range(0, 1) ? smfp_pkg::ST_SYSEX
                                                       : smfp_pkg::ST_ESCAPE);
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 4);
            vlq_to_trk(28'(len));
            repeat (len) trk_buf.push_back(8'($urandom_range(0, 255)));
            trk_run = '0;
        end
    endfunction

    function automatic void add_track(t_ending ending, bit last_trk);
        logic [7:0]  trk_run;
        logic [31:0] len;
        int          target;
        trk_buf.delete();
        trk_run = '0;
        target = $urandom_range(20, 60);
        if (last_trk && ending == END_NO_RUNNING) begin
            trk_buf.push_back(8'h00);
            trk_buf.push_back(8'($urandom_range(0, 127)));
        end
        while (trk_buf.size() < target) add_event(trk_run);
        if (last_trk && ending == END_BAD_STATUS) begin
            trk_buf.push_back(8'h00);
            trk_buf.push_back($urandom_range(0, 1) ? 8'hF1 : 8'($urandom_range(8'hF8, 8'hFE)));
        end
        if (last_trk && ending == END_OVERFLOW)
            repeat (4) trk_buf.push_back(8'hFF);
        len = 32'(trk_buf.size());
        if (last_trk && ending == END_PAST_CHUNK) len = len - 32'd1;
        if (last_trk && ending == END_EMPTY_TRACK) len = 32'd0;
        for (int i = 0; i < 4; i++)
            put_byte((last_trk && ending == END_BAD_ID && i == 3) ? 8'h00 : TRK_TAG[i]);
        for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8]);
        foreach (trk_buf[i]) put_byte(trk_buf[i]);
    endfunction

    function automatic void build_file();
        smfp_pkg::t_result hdr_res;
        smfp_pkg::t_result head_res;
        t_ending ending;
        logic [7:0] first_trk [16];
        hdr_res = '0;
        hdr_res.kind              = smfp_pkg::KIND_HEADER;
        hdr_res.file_format       = 2'd1;
        hdr_res.track_count       = 16'(N_TRACKS);
        hdr_res.smpte_timing      = 1'b1;
        hdr_res.frames_per_second = 7'h62;
        hdr_res.ticks_value       = 15'h0050;
        head_res = '0;
        head_res.kind           = smfp_pkg::KIND_HEAD;
        head_res.delta_ticks    = 28'h0FFFFFFF;
        head_res.status_byte    = 8'hC5;
        head_res.payload_length = 28'd1;
        // directed header: format 1, twelve tracks, SMPTE division
        foreach (HDR_TAG[i]) put_byte(HDR_TAG[i]);
        put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'h06);
        put_byte(8'h00); put_byte(8'h01);
        put_byte(8'h00); put_byte(8'(N_TRACKS));
        put_byte(8'hE2); put_pinned(8'h50, hdr_res);
        // directed first track: longest delta, one-byte channel event,
        // running status, empty meta event
        first_trk = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'hFF,
                      8'h00, 8'h3C,
                      8'h00, 8'hFF, 8'h01, 8'h00,
                      8'h00, 8'hF7, 8'h01, 8'h80};
        foreach (TRK_TAG[i]) put_byte(TRK_TAG[i]);
        put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'd16);
        foreach (first_trk[i]) begin
            if (i == 4) put_pinned(first_trk[i], head_res);
            else put_byte(first_trk[i]);
        end
        // random tracks, the final one carrying the chosen ending
        ending = t_ending'($urandom_range(0, 6));
        for (int t = 1; t < N_TRACKS; t++) begin
            if (t == 6) pause_at = file_q.size();
            add_track(ending, t == N_TRACKS - 1);
        end
        if (ending == END_TRAILING) put_byte(8'($urandom_range(0, 255)));
        // halted: these must give nothing
        repeat (8) put_byte(8'($urandom_range(0, 255)));
    endfunction

    // ---------------- result checking ----------------
    task automatic check_field(string name, logic [27:0] exp_v, logic [27:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    task automatic check_result(smfp_pkg::t_result e);
        check_field("kind", e.kind, o_kind);
        check_field("delta_ticks", e.delta_ticks, o_delta_ticks);
        check_field("status_byte", e.status_byte, o_status_byte);
        check_field("meta_type", e.meta_type, o_meta_type);
        check_field("payload_length", e.payload_length, o_payload_length);
        check_field("payload_byte", e.payload_byte, o_payload_byte);
        check_field("last_of_event", e.last_of_event, o_last_of_event);
        check_field("file_format", e.file_format, o_file_format);
        check_field("track_count", e.track_count, o_track_count);
        check_field("smpte_timing", e.smpte_timing, o_smpte_timing);
        check_field("frames_per_second", e.frames_per_second, o_frames_per_second);
        check_field("ticks_value", e.ticks_value, o_ticks_value);
    endtask

    // predict on accepted bytes, check accepted results
    always @(posedge i_clk) begin
        int n_before;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                n_before = pending_results.size();
                parse_byte(i_file_byte);
                if (pinned_q[n_accepted] && pending_results.size() > n_before)
                    pending_results[n_before] = pinned_res_q[n_accepted];
                n_accepted++;
            end
            if (o_valid && !i_stall) begin
                n_taken++;
                if (pending_results.size() == 0) begin
                    $error("result item with nothing expected, kind 0x%0h", o_kind);
                    mismatch_cnt++;
                end else begin
                    check_result(pending_results.pop_front());
                end
            end
        end
    end

    // ---------------- receiver stalls ----------------
    initial begin
        int  burst;
        int  hold;
        bit  held;
        logic nxt;
        burst = 0; hold = 0; held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_taken > 150) begin
                held = 1'b1;
                hold = 60;
            end
            if (hold > 0) begin
                hold--;
                nxt = 1'b1;
            end else if (calm) begin
                nxt = 1'b0;
            end else if (burst > 0) begin
                burst--;
                nxt = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 2);
                nxt = 1'b1;
            end else begin
                nxt = 1'b0;
            end
            i_stall = nxt;
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYC) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- sender and end of run ----------------
    initial begin
        parse_reset();
        build_file();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (file_q[i]) begin
            if (i == pause_at) begin
                i_valid = 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end
            if (i >= file_q.size() - CALM_TAIL) calm = 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            i_valid = 1'b1;
            i_file_byte = file_q[i];
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/smfp_pkg.sv
rtl/smfp_parser.sv
rtl/smfp_result_queue.sv
rtl/midi_file_stream_parser_top.sv
rtl/smfp_checker.sv
dv/tb_midi_file_stream_parser_top.sv
